FILE: hdl/ehd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ehd_pkg - shared types for the element header deframer
// Byte roles, parser phases and the labeled-byte result record.
// ============================================================================
package ehd_pkg;

    // Role of one stream byte within its element.
    typedef enum logic [1:0] {
        ROLE_TYPE    = 2'd0,
        ROLE_HEAD    = 2'd1,
        ROLE_EXT     = 2'd2,
        ROLE_CONTENT = 2'd3
    } t_role;

    // Parser phase: which kind of byte is expected next.
    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_HEAD    = 2'd1,
        PH_EXT     = 2'd2,
        PH_CONTENT = 2'd3
    } t_phase;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned SUB_W    = 6;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned IDX_W    = 2;

    // Fixed part of every element: the type byte and the length head byte.
    localparam logic [CNT_W-1:0] HDR_BYTES = 3'd2;

    // One labeled byte, as handed from the parser to the output register.
    typedef struct packed {
        t_role               role;
        logic [BYTE_W-1:0]   data_byte;
        logic [NIBBLE_W-1:0] element_number;
        logic [NIBBLE_W-1:0] parse_rule;
        logic [SUB_W-1:0]    head_bits;
        logic [CNT_W-1:0]    length_byte_count;
        logic [LEN_W-1:0]    element_length;
        logic                end_of_element;
        logic                short_length;
    } t_result;

endpackage

FILE: hdl/ehd_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// ehd_parser - element parsing state and byte labeling
// Holds the per-element state and labels one byte each time it is stepped.
// ============================================================================
module ehd_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [ehd_pkg::BYTE_W-1:0]       i_byte,
    output ehd_pkg::t_result                 o_result
);

    ehd_pkg::t_phase                  r_phase,        n_phase;
    logic [ehd_pkg::CNT_W-1:0]        r_ext_left,     n_ext_left;
    logic [ehd_pkg::IDX_W-1:0]        r_ext_index,    n_ext_index;
    logic [ehd_pkg::CNT_W-1:0]        r_ext_total,    n_ext_total;
    logic [ehd_pkg::LEN_W-1:0]        r_len_acc,      n_len_acc;
    logic [ehd_pkg::LEN_W-1:0]        r_content_left, n_content_left;
    logic [ehd_pkg::BYTE_W-1:0]       r_type_value,   n_type_value;
    logic [ehd_pkg::SUB_W-1:0]        r_head_info,    n_head_info;

    logic [ehd_pkg::CNT_W-1:0]        w_overhead;

    always_comb begin
        n_phase        = r_phase;
        n_ext_left     = r_ext_left;
        n_ext_index    = r_ext_index;
        n_ext_total    = r_ext_total;
        n_len_acc      = r_len_acc;
        n_content_left = r_content_left;
        n_type_value   = r_type_value;
        n_head_info    = r_head_info;
        w_overhead     = ehd_pkg::HDR_BYTES + r_ext_total;

        o_result                   = '0;
        o_result.data_byte         = i_byte;
        o_result.head_bits         = r_head_info;
        o_result.length_byte_count = r_ext_total;
        o_result.element_length    = r_len_acc;

        unique case (r_phase)
            ehd_pkg::PH_TYPE: begin
                n_type_value = i_byte;
                n_head_info  = '0;
                n_ext_total  = '0;
                n_len_acc    = '0;
                n_phase      = ehd_pkg::PH_HEAD;
                o_result.role              = ehd_pkg::ROLE_TYPE;
                o_result.head_bits         = '0;
                o_result.length_byte_count = '0;
                o_result.element_length    = '0;
            end
            ehd_pkg::PH_HEAD: begin
                n_head_info = i_byte[ehd_pkg::SUB_W-1:0];
                n_ext_total = {1'b0, i_byte[7:6]} + 3'd1;
                n_ext_left  = n_ext_total;
                n_ext_index = '0;
                n_len_acc   = '0;
                n_phase     = ehd_pkg::PH_EXT;
                o_result.role              = ehd_pkg::ROLE_HEAD;
                o_result.head_bits         = n_head_info;
                o_result.length_byte_count = n_ext_total;
                o_result.element_length    = '0;
            end
            ehd_pkg::PH_EXT: begin
                // Length arrives least significant byte first.
                unique case (r_ext_index)
                    2'd0: n_len_acc[7:0]   = r_len_acc[7:0]   | i_byte;
                    2'd1: n_len_acc[15:8]  = r_len_acc[15:8]  | i_byte;
                    2'd2: n_len_acc[23:16] = r_len_acc[23:16] | i_byte;
                    2'd3: n_len_acc[31:24] = r_len_acc[31:24] | i_byte;
                    default: n_len_acc = r_len_acc;
                endcase
                n_ext_index = r_ext_index + 2'd1;
                n_ext_left  = r_ext_left - 3'd1;
                o_result.role           = ehd_pkg::ROLE_EXT;
                o_result.element_length = n_len_acc;
                if (n_ext_left == '0) begin
                    // A total that leaves no content ends the element here.
                    if (n_len_acc <= {{(ehd_pkg::LEN_W-ehd_pkg::CNT_W){1'b0}}, w_overhead}) begin
                        o_result.end_of_element = 1'b1;
                        o_result.short_length   = 1'b1;
                        n_content_left          = '0;
                        n_phase                 = ehd_pkg::PH_TYPE;
                    end else begin
                        n_content_left = n_len_acc -
                            {{(ehd_pkg::LEN_W-ehd_pkg::CNT_W){1'b0}}, w_overhead};
                        n_phase        = ehd_pkg::PH_CONTENT;
                    end
                end
            end
            ehd_pkg::PH_CONTENT: begin
                o_result.role  = ehd_pkg::ROLE_CONTENT;
                n_content_left = r_content_left - 32'd1;
                if (n_content_left == '0) begin
                    o_result.end_of_element = 1'b1;
                    n_phase                 = ehd_pkg::PH_TYPE;
                end
            end
            default: begin
                n_phase = ehd_pkg::PH_TYPE;
            end
        endcase

        o_result.element_number = n_type_value[3:0];
        o_result.parse_rule     = n_type_value[7:4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ehd_pkg::PH_TYPE;
            r_ext_left     <= '0;
            r_ext_index    <= '0;
            r_ext_total    <= '0;
            r_len_acc      <= '0;
            r_content_left <= '0;
            r_type_value   <= '0;
            r_head_info    <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_ext_left     <= n_ext_left;
            r_ext_index    <= n_ext_index;
            r_ext_total    <= n_ext_total;
            r_len_acc      <= n_len_acc;
            r_content_left <= n_content_left;
            r_type_value   <= n_type_value;
            r_head_info    <= n_head_info;
        end
    end

endmodule

FILE: hdl/element_header_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// element_header_deframer - labels each byte of a stream of elements
// Tracks type, length head, little-endian length and content bytes and
// tags every byte with its role and the header fields of its element.
// ============================================================================
// Throughput is one word per clock cycle, sustained while the output is
// ready: each byte needs only a small update of the element state (a 32-bit
// compare and subtract on the last length byte, a 32-bit decrement per
// content byte), all done in a single pass between the input register and
// the output register. An accepted input word goes into the input register
// and then into the output register. While a finished word waits on the
// output, the input register still takes one more word; after that the
// input stalls until the output is drained.
// Each input word yields exactly one output word. The stream has no framing
// of its own: a byte after a run that ended mid-element simply continues
// that element. m_axis_tlast marks the last byte of each element, and the
// short_length flag in m_axis_tuser marks an element whose total length
// leaves no content, which then ends on its last length byte.
module element_header_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // Labeled byte stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] data_byte, [11:8] element_number,
                                        // [15:12] parse_rule, [21:16] head_bits,
                                        // [24:22] length_byte_count,
                                        // [56:25] element_length, [63:57] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] byte_role, [2] short_length
    output logic        m_axis_tlast    // end_of_element
);

    logic                         r_in_valid;
    logic [ehd_pkg::BYTE_W-1:0]   r_in_byte;
    logic                         r_out_valid;
    ehd_pkg::t_result             r_out;

    logic                         w_advance;
    logic                         w_step;
    ehd_pkg::t_result             w_result;

    // The output register can be loaded when it is empty or being drained.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // The parser advances its element state only when its byte moves into
    // the output register, so stalls never skip or repeat a byte.
    ehd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0,
                            r_out.element_length,
                            r_out.length_byte_count,
                            r_out.head_bits,
                            r_out.parse_rule,
                            r_out.element_number,
                            r_out.data_byte};
    assign m_axis_tuser  = {r_out.short_length, r_out.role};
    assign m_axis_tlast  = r_out.end_of_element;

endmodule

FILE: bench/element_header_deframer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// element_header_deframer_tb - self-checking bench for the element deframer
// Feeds a byte stream of elements through the block: a short table of
// hand-picked elements first, then randomly built elements, and last one
// element with the largest possible length that is left unfinished. Each
// accepted byte runs through a behavioral copy of the parser, and every
// labeled output word is compared field by field with the oldest prediction.
// ============================================================================
module element_header_deframer_tb;

    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 16;
    // The receiver's long hold-off starts at this cycle, while bytes are still
    // being offered, so the block fills up and has to stall its input.
    localparam int unsigned HOLD_START   = 1200;
    localparam int unsigned HOLD_CYCLES  = 300;

    // One stimulus byte. Where typed is set, the role, length and end flags
    // listed here replace the predicted ones, so they are checked as typed.
    typedef struct packed {
        logic [7:0]     stream_byte;
        logic           typed;
        ehd_pkg::t_role role;
        logic [31:0]    element_length;
        logic           end_of_element;
        logic           short_length;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] stream_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [7:0] data_byte, [11:8] element_number,
                                       // [15:12] parse_rule, [21:16] head_bits,
                                       // [24:22] length_byte_count,
                                       // [56:25] element_length, [63:57] zero
    logic [2:0]  m_axis_tuser;         // [1:0] byte_role, [2] short_length
    logic        m_axis_tlast;         // end_of_element

    // Row that goes with the byte currently offered on the input.
    t_stim_row   offered_row = '0;

    element_header_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Parser copy: the element state as the block should hold it.
    // ------------------------------------------------------------------------
    ehd_pkg::t_phase parse_phase  = ehd_pkg::PH_TYPE;
    logic [2:0]      ext_left     = '0;
    logic [1:0]      ext_index    = '0;
    logic [2:0]      ext_total    = '0;
    logic [31:0]     length_sum   = '0;
    logic [31:0]     content_left = '0;
    logic [7:0]      type_byte    = '0;
    logic [5:0]      head_sub     = '0;

    // Labeled bytes still owed by the block, oldest first.
    ehd_pkg::t_result expected_labels[$];
    int unsigned      mismatches = 0;

    // Works out the label of one stream byte and moves the parser state on.
    function automatic ehd_pkg::t_result label_byte(input logic [7:0] b);
        ehd_pkg::t_result lbl;
        logic [31:0]      overhead;
        lbl           = '0;
        lbl.data_byte = b;
        case (parse_phase)
            ehd_pkg::PH_TYPE: begin
                type_byte   = b;
                head_sub    = '0;
                ext_total   = '0;
                length_sum  = '0;
                lbl.role    = ehd_pkg::ROLE_TYPE;
                parse_phase = ehd_pkg::PH_HEAD;
            end
            ehd_pkg::PH_HEAD: begin
                head_sub              = b[5:0];
                ext_total             = {1'b0, b[7:6]} + 3'd1;
                ext_left              = ext_total;
                ext_index             = '0;
                length_sum            = '0;
                lbl.role              = ehd_pkg::ROLE_HEAD;
                lbl.head_bits         = head_sub;
                lbl.length_byte_count = ext_total;
                parse_phase           = ehd_pkg::PH_EXT;
            end
            ehd_pkg::PH_EXT: begin
                // Length bytes arrive least significant first.
                length_sum            = length_sum | ({24'd0, b} << (8 * ext_index));
                ext_index             = ext_index + 2'd1;
                ext_left              = ext_left - 3'd1;
                lbl.role              = ehd_pkg::ROLE_EXT;
                lbl.head_bits         = head_sub;
                lbl.length_byte_count = ext_total;
                lbl.element_length    = length_sum;
                if (ext_left == 3'd0) begin
                    // The total counts the type byte, the head byte and the
                    // length bytes; whatever is left over is content.
                    overhead = 32'(ehd_pkg::HDR_BYTES) + 32'(ext_total);
                    if (length_sum <= overhead) begin
                        lbl.end_of_element = 1'b1;
                        lbl.short_length   = 1'b1;
                        content_left       = '0;
                        parse_phase        = ehd_pkg::PH_TYPE;
                    end else begin
                        content_left = length_sum - overhead;
                        parse_phase  = ehd_pkg::PH_CONTENT;
                    end
                end
            end
            default: begin
                lbl.role              = ehd_pkg::ROLE_CONTENT;
                lbl.head_bits         = head_sub;
                lbl.length_byte_count = ext_total;
                lbl.element_length    = length_sum;
                content_left          = content_left - 32'd1;
                if (content_left == 32'd0) begin
                    lbl.end_of_element = 1'b1;
                    parse_phase        = ehd_pkg::PH_TYPE;
                end
            end
        endcase
        lbl.element_number = type_byte[3:0];
        lbl.parse_rule     = type_byte[7:4];
        return lbl;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard. Input and output handshakes are looked at in the same block,
    // so a prediction is always queued before its word can be compared.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        ehd_pkg::t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = label_byte(s_axis_tdata);
                if (offered_row.typed) begin
                    want.role           = offered_row.role;
                    want.element_length = offered_row.element_length;
                    want.end_of_element = offered_row.end_of_element;
                    want.short_length   = offered_row.short_length;
                end
                expected_labels.insert(expected_labels.size(), want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_labels.size() == 0) begin
                    $error("output word %0h arrived with nothing expected", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_labels.pop_front();
                    check_field("byte_role", 64'(want.role), 64'(m_axis_tuser[1:0]));
                    check_field("data_byte", 64'(want.data_byte),
                                64'(m_axis_tdata[7:0]));
                    check_field("element_number", 64'(want.element_number),
                                64'(m_axis_tdata[11:8]));
                    check_field("parse_rule", 64'(want.parse_rule),
                                64'(m_axis_tdata[15:12]));
                    check_field("head_bits", 64'(want.head_bits),
                                64'(m_axis_tdata[21:16]));
                    check_field("length_byte_count", 64'(want.length_byte_count),
                                64'(m_axis_tdata[24:22]));
                    check_field("element_length", 64'(want.element_length),
                                64'(m_axis_tdata[56:25]));
                    check_field("tdata padding", 64'd0, 64'(m_axis_tdata[63:57]));
                    check_field("end_of_element", 64'(want.end_of_element),
                                64'(m_axis_tlast));
                    check_field("short_length", 64'(want.short_length),
                                64'(m_axis_tuser[2]));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: a stall pattern picked at random from four modes, plus one long
    // hold-off in the middle of the random part.
    // ------------------------------------------------------------------------
    int unsigned rx_cycle  = 0;
    int unsigned rx_mode   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 50 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= rx_cycle[2];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, with random gaps between them.
    // ------------------------------------------------------------------------
    int unsigned burst_left   = 0;
    int unsigned random_words = 0;

    task automatic offer_word(input t_stim_row row);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tdata  <= row.stream_byte;
        offered_row   <= row;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Builds one whole element with a random type, sub-info and length
    // byte count. Most totals are small; some are short, some use the full
    // first length byte, and a few reach into the second one.
    task automatic send_random_element();
        t_stim_row   row;
        int unsigned n_ext;
        int unsigned total;
        int unsigned n_content;
        int unsigned pick;
        row   = '0;
        n_ext = $urandom_range(1, 4);
        pick  = $urandom_range(0, 99);
        if (pick < 15)
            total = $urandom_range(0, 2 + n_ext);
        else if (pick < 80)
            total = 2 + n_ext + $urandom_range(1, 12);
        else if (pick < 95 || n_ext == 1)
            total = $urandom_range(0, 255);
        else
            total = $urandom_range(256, 290);
        n_content = (total > 2 + n_ext) ? total - 2 - n_ext : 0;

        row.stream_byte = 8'($urandom_range(0, 255));
        offer_word(row);
        row.stream_byte = {2'(n_ext - 1), 6'($urandom_range(0, 63))};
        offer_word(row);
        for (int i = 0; i < n_ext; i++) begin
            row.stream_byte = 8'(total >> (8 * i));
            offer_word(row);
        end
        for (int i = 0; i < n_content; i++) begin
            row.stream_byte = 8'($urandom_range(0, 255));
            offer_word(row);
        end
        random_words += 2 + n_ext + n_content;
    endtask

    // Hand-picked elements: one length byte with one content byte and the
    // all-ones type byte; four length bytes of zero total (short); a total
    // exactly equal to the header size (short, at the boundary); a total one
    // above the header size with the largest sub-info.
    t_stim_row lead_rows [0:19];
    // Largest unsigned total, which must not be taken as negative. It can
    // never finish, so it goes last and leaves the stream mid-element.
    t_stim_row tail_rows [0:8];

    initial begin
        lead_rows = '{
            '{8'hFF, 1'b1, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_HEAD,    32'd0, 1'b0, 1'b0},
            '{8'h04, 1'b1, ehd_pkg::ROLE_EXT,     32'd4, 1'b0, 1'b0},
            '{8'hAB, 1'b1, ehd_pkg::ROLE_CONTENT, 32'd4, 1'b1, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'hC0, 1'b1, ehd_pkg::ROLE_HEAD,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_EXT,     32'd0, 1'b1, 1'b1},
            '{8'h3C, 1'b1, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h40, 1'b1, ehd_pkg::ROLE_HEAD,    32'd0, 1'b0, 1'b0},
            '{8'h04, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_EXT,     32'd4, 1'b1, 1'b1},
            '{8'hA5, 1'b1, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'hBF, 1'b1, ehd_pkg::ROLE_HEAD,    32'd0, 1'b0, 1'b0},
            '{8'h06, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0, 1'b0, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_EXT,     32'd6, 1'b0, 1'b0},
            '{8'h7E, 1'b1, ehd_pkg::ROLE_CONTENT, 32'd6, 1'b1, 1'b0}
        };
        tail_rows = '{
            '{8'h81, 1'b1, ehd_pkg::ROLE_TYPE,    32'd0,        1'b0, 1'b0},
            '{8'hFF, 1'b1, ehd_pkg::ROLE_HEAD,    32'd0,        1'b0, 1'b0},
            '{8'hFF, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0,        1'b0, 1'b0},
            '{8'hFF, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0,        1'b0, 1'b0},
            '{8'hFF, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0,        1'b0, 1'b0},
            '{8'hFF, 1'b1, ehd_pkg::ROLE_EXT,     32'hFFFFFFFF, 1'b0, 1'b0},
            '{8'h00, 1'b1, ehd_pkg::ROLE_CONTENT, 32'hFFFFFFFF, 1'b0, 1'b0},
            '{8'hFF, 1'b0, ehd_pkg::ROLE_TYPE,    32'd0,        1'b0, 1'b0},
            '{8'h55, 1'b1, ehd_pkg::ROLE_CONTENT, 32'hFFFFFFFF, 1'b0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (lead_rows[i]) offer_word(lead_rows[i]);
        while (random_words < RANDOM_WORDS) send_random_element();
        foreach (tail_rows[i]) offer_word(tail_rows[i]);
        s_axis_tvalid <= 1'b0;

        // Let every owed word come out, then watch a while for strays.
        do @(posedge i_clk); while (expected_labels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_labels.size() != 0) begin
            $error("output words: expected %0d more, got 0", expected_labels.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
